// File: design/sha512_pkg.sv
// sha512_pkg: shared constants, types and constant tables of the sha-512 hash engine
// used by sha512_compress and sha512_hash_engine; no dependencies

package sha512_pkg;

	localparam int WORD_W      = 64;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS      = 80;
	localparam int DIGEST_WORDS = 8;

	localparam int RND_W = $clog2(ROUNDS);
	localparam int POS_W = $clog2(BLOCK_WORDS);
	localparam int DIG_W = $clog2(DIGEST_WORDS);

	// word positions inside a block, last round index and last digest word index
	localparam logic [POS_W-1:0] LEN_POS   = POS_W'(BLOCK_WORDS - 2);
	localparam logic [POS_W-1:0] BLOCK_END = POS_W'(BLOCK_WORDS - 1);
	localparam logic [RND_W-1:0] LAST_RND  = RND_W'(ROUNDS - 1);
	localparam logic [DIG_W-1:0] LAST_DIG  = DIG_W'(DIGEST_WORDS - 1);

	// padding marker byte and byte count of a full word
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [3:0] FULL_BYTES = 4'd8;

	// requests from the sequencer to the compression unit
	typedef struct packed {
		logic              push;
		logic [WORD_W-1:0] push_data;
		logic              start;
		logic              reinit;
		logic [DIG_W-1:0]  rd_idx;
	} cmp_ctrl_t;

	// status from the compression unit
	typedef struct packed {
		logic busy;
		logic done;
	} cmp_stat_t;

	// initial hash value
	function automatic logic [WORD_W-1:0] init_hash(input logic [DIG_W-1:0] idx);
		logic [WORD_W-1:0] v;
		case (idx)
			3'd0: v = 64'h6a09e667f3bcc908;
			3'd1: v = 64'hbb67ae8584caa73b;
			3'd2: v = 64'h3c6ef372fe94f82b;
			3'd3: v = 64'ha54ff53a5f1d36f1;
			3'd4: v = 64'h510e527fade682d1;
			3'd5: v = 64'h9b05688c2b3e6c1f;
			3'd6: v = 64'h1f83d9abfb41bd6b;
			default: v = 64'h5be0cd19137e2179;
		endcase
		return v;
	endfunction

	// round constants
	function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] idx);
		logic [WORD_W-1:0] v;
		case (idx)
			7'd0:  v = 64'h428a2f98d728ae22;
			7'd1:  v = 64'h7137449123ef65cd;
			7'd2:  v = 64'hb5c0fbcfec4d3b2f;
			7'd3:  v = 64'he9b5dba58189dbbc;
			7'd4:  v = 64'h3956c25bf348b538;
			7'd5:  v = 64'h59f111f1b605d019;
			7'd6:  v = 64'h923f82a4af194f9b;
			7'd7:  v = 64'hab1c5ed5da6d8118;
			7'd8:  v = 64'hd807aa98a3030242;
			7'd9:  v = 64'h12835b0145706fbe;
			7'd10: v = 64'h243185be4ee4b28c;
			7'd11: v = 64'h550c7dc3d5ffb4e2;
			7'd12: v = 64'h72be5d74f27b896f;
			7'd13: v = 64'h80deb1fe3b1696b1;
			7'd14: v = 64'h9bdc06a725c71235;
			7'd15: v = 64'hc19bf174cf692694;
			7'd16: v = 64'he49b69c19ef14ad2;
			7'd17: v = 64'hefbe4786384f25e3;
			7'd18: v = 64'h0fc19dc68b8cd5b5;
			7'd19: v = 64'h240ca1cc77ac9c65;
			7'd20: v = 64'h2de92c6f592b0275;
			7'd21: v = 64'h4a7484aa6ea6e483;
			7'd22: v = 64'h5cb0a9dcbd41fbd4;
			7'd23: v = 64'h76f988da831153b5;
			7'd24: v = 64'h983e5152ee66dfab;
			7'd25: v = 64'ha831c66d2db43210;
			7'd26: v = 64'hb00327c898fb213f;
			7'd27: v = 64'hbf597fc7beef0ee4;
			7'd28: v = 64'hc6e00bf33da88fc2;
			7'd29: v = 64'hd5a79147930aa725;
			7'd30: v = 64'h06ca6351e003826f;
			7'd31: v = 64'h142929670a0e6e70;
			7'd32: v = 64'h27b70a8546d22ffc;
			7'd33: v = 64'h2e1b21385c26c926;
			7'd34: v = 64'h4d2c6dfc5ac42aed;
			7'd35: v = 64'h53380d139d95b3df;
			7'd36: v = 64'h650a73548baf63de;
			7'd37: v = 64'h766a0abb3c77b2a8;
			7'd38: v = 64'h81c2c92e47edaee6;
			7'd39: v = 64'h92722c851482353b;
			7'd40: v = 64'ha2bfe8a14cf10364;
			7'd41: v = 64'ha81a664bbc423001;
			7'd42: v = 64'hc24b8b70d0f89791;
			7'd43: v = 64'hc76c51a30654be30;
			7'd44: v = 64'hd192e819d6ef5218;
			7'd45: v = 64'hd69906245565a910;
			7'd46: v = 64'hf40e35855771202a;
			7'd47: v = 64'h106aa07032bbd1b8;
			7'd48: v = 64'h19a4c116b8d2d0c8;
			7'd49: v = 64'h1e376c085141ab53;
			7'd50: v = 64'h2748774cdf8eeb99;
			7'd51: v = 64'h34b0bcb5e19b48a8;
			7'd52: v = 64'h391c0cb3c5c95a63;
			7'd53: v = 64'h4ed8aa4ae3418acb;
			7'd54: v = 64'h5b9cca4f7763e373;
			7'd55: v = 64'h682e6ff3d6b2b8a3;
			7'd56: v = 64'h748f82ee5defb2fc;
			7'd57: v = 64'h78a5636f43172f60;
			7'd58: v = 64'h84c87814a1f0ab72;
			7'd59: v = 64'h8cc702081a6439ec;
			7'd60: v = 64'h90befffa23631e28;
			7'd61: v = 64'ha4506cebde82bde9;
			7'd62: v = 64'hbef9a3f7b2c67915;
			7'd63: v = 64'hc67178f2e372532b;
			7'd64: v = 64'hca273eceea26619c;
			7'd65: v = 64'hd186b8c721c0c207;
			7'd66: v = 64'heada7dd6cde0eb1e;
			7'd67: v = 64'hf57d4f7fee6ed178;
			7'd68: v = 64'h06f067aa72176fba;
			7'd69: v = 64'h0a637dc5a2c898a6;
			7'd70: v = 64'h113f9804bef90dae;
			7'd71: v = 64'h1b710b35131c471b;
			7'd72: v = 64'h28db77f523047d84;
			7'd73: v = 64'h32caab7b40c72493;
			7'd74: v = 64'h3c9ebe0a15c9bebc;
			7'd75: v = 64'h431d67c49c100d4c;
			7'd76: v = 64'h4cc5d4becb3e42b6;
			7'd77: v = 64'h597f299cfc657e2a;
			7'd78: v = 64'h5fcb6fab3ad6faec;
			7'd79: v = 64'h6c44198c4a475817;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: design/sha512_compress.sv
// sha512_compress: block window, message schedule, one shared round unit and chaining value
// depends on sha512_pkg (types, round constants, initial hash value)

module sha512_compress (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sha512_pkg::cmp_ctrl_t              ctrl,
	output sha512_pkg::cmp_stat_t              stat,
	output logic [sha512_pkg::WORD_W-1:0]      rd_data
);

	localparam int W = sha512_pkg::WORD_W;

	function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input int n);
		return (x >> n) | (x << (W - n));
	endfunction

	logic [W-1:0] w_q     [sha512_pkg::BLOCK_WORDS];
	logic [W-1:0] wv_q    [sha512_pkg::DIGEST_WORDS];
	logic [W-1:0] chain_q [sha512_pkg::DIGEST_WORDS];
	logic [sha512_pkg::RND_W-1:0] round_q;
	logic run_q;
	logic fold_q;

	logic [W-1:0] t1, t2, big0, big1, choose, major, lo_sig, hi_sig, sched_new;

	// one round of the compression function and one schedule step
	always_comb begin
		big1   = rotr(wv_q[4], 14) ^ rotr(wv_q[4], 18) ^ rotr(wv_q[4], 41);
		choose = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		t1     = wv_q[7] + big1 + choose + sha512_pkg::round_k(round_q) + w_q[0];
		big0   = rotr(wv_q[0], 28) ^ rotr(wv_q[0], 34) ^ rotr(wv_q[0], 39);
		major  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t2     = big0 + major;
		lo_sig = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		hi_sig = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		sched_new = w_q[0] + lo_sig + w_q[9] + hi_sig;
	end

	// block window: loaded by pushes, then slid by the schedule during rounds
	always_ff @(posedge clk) begin
		if (ctrl.push || run_q) begin
			for (int i = 0; i < sha512_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha512_pkg::BLOCK_WORDS-1] <= run_q ? sched_new : ctrl.push_data;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < sha512_pkg::DIGEST_WORDS; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (run_q) begin
			wv_q[0] <= t1 + t2;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= wv_q[1];
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[5] <= wv_q[4];
			wv_q[6] <= wv_q[5];
			wv_q[7] <= wv_q[6];
		end
	end

	// round sequencer and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fold_q  <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < sha512_pkg::DIGEST_WORDS; i++) begin
				chain_q[i] <= sha512_pkg::init_hash(sha512_pkg::DIG_W'(i));
			end
		end else begin
			fold_q <= 1'b0;
			if (ctrl.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 1'b1;
				if (round_q == sha512_pkg::LAST_RND) begin
					run_q  <= 1'b0;
					fold_q <= 1'b1;
				end
			end
			if (fold_q) begin
				for (int i = 0; i < sha512_pkg::DIGEST_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
			end else if (ctrl.reinit) begin
				for (int i = 0; i < sha512_pkg::DIGEST_WORDS; i++) begin
					chain_q[i] <= sha512_pkg::init_hash(sha512_pkg::DIG_W'(i));
				end
			end
		end
	end

	assign stat.busy = run_q || fold_q;
	assign stat.done = fold_q;
	assign rd_data   = chain_q[ctrl.rd_idx];

endmodule

// File: design/sha512_hash_engine.sv
// sha512_hash_engine: sha-512 hash of a word stream, padding sequencer and digest output
// depends on sha512_pkg and sha512_compress

// Usage
// The input channel s_* carries message words: s_tdata is the 64-bit word with its first
// byte in bits 63:56, s_tuser the count of valid leading bytes, s_tlast the final word.
// The output channel m_* carries the eight 64-bit digest words, word 0 first, with m_tlast
// on the eighth.
// Timing: in the idle state a word that does not complete a block is taken as soon as it is
// valid. The sixteenth word of a block starts the shared round unit, which does one round
// per cycle over 80 rounds and then folds the result into the chaining value; s_tready is
// low meanwhile. The last word is followed by the padding words at one per cycle and one or
// two compressions, then eight digest items. While m_tready is low the current digest word
// holds and no input is taken; the block reloads the initial hash value and clears its
// length counter after the eighth digest item is taken, when its word counter has already
// wrapped to zero. Reset loads the initial hash value and clears all counters; the block is
// ready for a new message right after reset.

module sha512_hash_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sha512_pkg::WORD_W-1:0] s_tdata,   // message_word
	input  logic [3:0]                    s_tuser,   // valid_bytes
	input  logic                          s_tlast,   // last_word
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sha512_pkg::WORD_W-1:0] m_tdata,   // digest_word
	output logic                          m_tlast    // last_digest_word
);

	localparam int W = sha512_pkg::WORD_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [sha512_pkg::POS_W-1:0] cnt_q;
	logic [W-1:0]                 bit_len_q;
	logic                         pad_q;
	logic                         mark_q;
	logic                         final_q;
	logic [sha512_pkg::DIG_W-1:0] out_idx_q;

	sha512_pkg::cmp_ctrl_t ctrl;
	sha512_pkg::cmp_stat_t stat;
	logic [W-1:0]          rd_data;

	logic          in_acc;
	logic          out_acc;
	logic [3:0]    nbytes;
	logic [W-1:0]  tail_word;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// saturate the byte count and build the last word with its marker byte
	always_comb begin
		nbytes = s_tuser[3] ? sha512_pkg::FULL_BYTES : s_tuser;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) < nbytes) begin
				tail_word[W-1-8*j -: 8] = s_tdata[W-1-8*j -: 8];
			end else if (4'(j) == nbytes) begin
				tail_word[W-1-8*j -: 8] = sha512_pkg::PAD_MARK;
			end else begin
				tail_word[W-1-8*j -: 8] = 8'h00;
			end
		end
	end

	// requests to the compression unit
	always_comb begin
		ctrl.push      = 1'b0;
		ctrl.push_data = '0;
		ctrl.reinit    = out_acc && (out_idx_q == sha512_pkg::LAST_DIG);
		ctrl.rd_idx    = out_idx_q;
		case (state_q)
			ST_IDLE: begin
				ctrl.push      = s_tvalid;
				ctrl.push_data = (s_tlast && (nbytes != sha512_pkg::FULL_BYTES)) ?
						tail_word : s_tdata;
			end
			ST_PAD: begin
				ctrl.push = 1'b1;
				if (mark_q) begin
					ctrl.push_data = {sha512_pkg::PAD_MARK, {(W-8){1'b0}}};
				end else if (final_q && (cnt_q == sha512_pkg::BLOCK_END)) begin
					ctrl.push_data = bit_len_q;
				end
			end
			default: ;
		endcase
		ctrl.start = ctrl.push && (cnt_q == sha512_pkg::BLOCK_END);
	end

	sha512_compress u_compress (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.rd_data (rd_data)
	);

	// sequencer: gather, pad, compress, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			bit_len_q <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			final_q   <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (ctrl.push) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!s_tlast) begin
							bit_len_q <= bit_len_q + W'(64);
							if (ctrl.start) begin
								state_q <= ST_COMP;
							end
						end else begin
							bit_len_q <= bit_len_q + W'({nbytes, 3'b000});
							pad_q     <= 1'b1;
							if (nbytes == sha512_pkg::FULL_BYTES) begin
								mark_q <= 1'b1;
							end else begin
								final_q <= (cnt_q < sha512_pkg::LEN_POS);
							end
							state_q <= ctrl.start ? ST_COMP : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (mark_q) begin
						mark_q  <= 1'b0;
						final_q <= (cnt_q < sha512_pkg::LEN_POS);
					end
					if (ctrl.start) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (stat.done) begin
						if (!pad_q) begin
							state_q <= ST_IDLE;
						end else if (mark_q) begin
							state_q <= ST_PAD;
						end else if (final_q) begin
							state_q <= ST_OUT;
						end else begin
							final_q <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == sha512_pkg::LAST_DIG) begin
							bit_len_q <= '0;
							pad_q     <= 1'b0;
							final_q   <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// channel outputs
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = rd_data;
	assign m_tlast  = m_tvalid && (out_idx_q == sha512_pkg::LAST_DIG);

	// the block never takes input while a digest is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while digest pending");

	// a compression only ends while the sequencer waits for it
	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == ST_COMP))
		else $error("compression done outside wait state");

	// after the final digest item the block is ready with cleared counters
	a_ready_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (s_tready && (cnt_q == '0) && (bit_len_q == '0)))
		else $error("block not reset after digest");

	// the round unit is never started while it is busy
	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !stat.busy)
		else $error("compression started while busy");

endmodule
